/* rtl/keypad_code_alarm_controller_defines.svh */
// ----------------------------------------------------------------------------
// Keypad code alarm controller: assertion macros
// Shared checking macros; they expect clk and arst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_ALARM_CONTROLLER_DEFINES_SVH
`define KEYPAD_CODE_ALARM_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KCAC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kcac: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define KCAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kcac: next-cycle check failed");

`endif

/* rtl/kcac_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad code alarm controller package
// Sizes, codes, shared structs and the keypad map.
// ----------------------------------------------------------------------------
`default_nettype none

package kcac_pkg;

	// Entry buffer sizing
	localparam int ENTRY_CAPACITY   = 18;
	localparam int CNT_W            = $clog2(ENTRY_CAPACITY + 1);
	localparam int IDX_W            = $clog2(ENTRY_CAPACITY);
	localparam int MAX_CODE_SYMBOLS = 16;
	localparam int CMP_N            = (ENTRY_CAPACITY < MAX_CODE_SYMBOLS) ?
		ENTRY_CAPACITY : MAX_CODE_SYMBOLS;

	// Symbols
	localparam logic [3:0] SYM_STAR = 4'd10;

	// Item opcodes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [3:0] CFG_CODE_SYMBOLS = 4'd0;
	localparam logic [3:0] CFG_CODE_LENGTH  = 4'd1;
	localparam logic [3:0] CFG_WRONG_LIMIT  = 4'd2;
	localparam logic [3:0] CFG_ARM_DELAY    = 4'd3;

	// Reset values of the configuration registers
	localparam logic [63:0] RST_CODE_SYMBOLS = 64'd6636321;
	localparam logic [4:0]  RST_CODE_LENGTH  = 5'd6;
	localparam logic [3:0]  RST_WRONG_LIMIT  = 4'd3;
	localparam logic [5:0]  RST_ARM_DELAY    = 6'd30;

	typedef enum logic [1:0] {
		MODE_DISARMED   = 2'd0,
		MODE_ACTIVATING = 2'd1,
		MODE_ARMED      = 2'd2,
		MODE_ALARM      = 2'd3
	} lock_mode_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_ARM_START   = 3'd1,
		EV_ARM_REFUSED = 3'd2,
		EV_DISARMED    = 3'd3,
		EV_NOT_ACTIVE  = 3'd4,
		EV_WRONG_CODE  = 3'd5,
		EV_ALARM       = 3'd6,
		EV_ARMED       = 3'd7
	} event_t;

	// Decoded key of one scan
	typedef struct packed {
		logic       hit;
		logic       enter;
		logic [3:0] sym;
	} key_t;

	// Configuration seen by the lock
	typedef struct packed {
		logic [63:0] code_symbols;
		logic [4:0]  code_length;
		logic [3:0]  wrong_limit;
		logic [5:0]  arm_delay;
	} cfg_t;

	// Lock status after one item
	typedef struct packed {
		lock_mode_t  mode;
		logic [3:0]  wrong_count;
		event_t      ev;
		logic [4:0]  entry_length;
	} lock_res_t;

	// Key at a column, rows by priority with row 0 first
	function automatic key_t decode_key(input logic [1:0] col, input logic [3:0] rows);
		key_t       k;
		logic [1:0] r;
		k   = '0;
		r   = 2'd0;
		if (rows[0])      r = 2'd0;
		else if (rows[1]) r = 2'd1;
		else if (rows[2]) r = 2'd2;
		else              r = 2'd3;
		k.hit = |rows;
		case (col)
			2'd1: begin
				case (r)
					2'd0:    k.sym = 4'd0;
					2'd1:    k.sym = 4'd8;
					2'd2:    k.sym = 4'd5;
					default: k.sym = 4'd2;
				endcase
			end
			2'd2: begin
				case (r)
					2'd0:    k.enter = k.hit;
					2'd1:    k.sym = 4'd9;
					2'd2:    k.sym = 4'd6;
					default: k.sym = 4'd3;
				endcase
			end
			default: begin
				case (r)
					2'd0:    k.sym = SYM_STAR;
					2'd1:    k.sym = 4'd7;
					2'd2:    k.sym = 4'd4;
					default: k.sym = 4'd1;
				endcase
			end
		endcase
		if (!k.hit || k.enter) k.sym = 4'd0;
		return k;
	endfunction

endpackage

`default_nettype wire

/* rtl/kcac_lock.sv */
// ----------------------------------------------------------------------------
// Keypad code alarm controller: lock core
// Entry buffer, code compare, arming countdown and lock mode.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypad_code_alarm_controller_defines.svh"

module kcac_lock (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              tick,
	input  wire kcac_pkg::key_t    key,
	input  wire kcac_pkg::cfg_t    cfg,
	output kcac_pkg::lock_res_t    res
);

	kcac_pkg::lock_mode_t            mode_q, mode_d;
	logic [3:0]                      tally_q, tally_d, tally_inc;
	logic [5:0]                      countdown_q, countdown_d;
	logic [kcac_pkg::CNT_W-1:0]      count_q, count_d;
	logic [3:0]                      entry_q [kcac_pkg::ENTRY_CAPACITY];
	logic                            full;
	logic [kcac_pkg::IDX_W-1:0]      wr_idx;
	logic                            wr_en;
	logic                            lone_star;
	logic                            match;
	logic [5:0]                      count_wide;
	kcac_pkg::event_t                ev;

	// Buffer write slot; a full buffer restarts at the first slot
	assign full   = (count_q == kcac_pkg::CNT_W'(kcac_pkg::ENTRY_CAPACITY));
	assign wr_idx = full ? '0 : count_q[kcac_pkg::IDX_W-1:0];

	// Entry is a single star
	assign lone_star = (count_q == kcac_pkg::CNT_W'(1)) && (entry_q[0] == kcac_pkg::SYM_STAR);

	// Parallel compare of the entry with the expected code
	always_comb begin
		match = (cfg.code_length <= 5'(kcac_pkg::MAX_CODE_SYMBOLS)) &&
			(6'(count_q) == 6'(cfg.code_length));
		for (int i = 0; i < kcac_pkg::CMP_N; i++) begin
			if ((5'(i) < cfg.code_length) && (entry_q[i] != cfg.code_symbols[4*i +: 4]))
				match = 1'b0;
		end
	end

	assign tally_inc = tally_q + 4'd1;

	// Next lock state for the item in hand
	always_comb begin
		mode_d      = mode_q;
		tally_d     = tally_q;
		countdown_d = countdown_q;
		count_d     = count_q;
		ev          = kcac_pkg::EV_NONE;
		wr_en       = 1'b0;
		if (step) begin
			if (tick) begin
				if (mode_q == kcac_pkg::MODE_ACTIVATING) begin
					if (countdown_q <= 6'd1) begin
						countdown_d = 6'd0;
						mode_d      = kcac_pkg::MODE_ARMED;
						ev          = kcac_pkg::EV_ARMED;
					end else begin
						countdown_d = countdown_q - 6'd1;
					end
				end
			end else if (key.enter) begin
				count_d = '0;
				if (lone_star) begin
					if (mode_q != kcac_pkg::MODE_DISARMED) begin
						ev = kcac_pkg::EV_ARM_REFUSED;
					end else begin
						mode_d      = kcac_pkg::MODE_ACTIVATING;
						countdown_d = cfg.arm_delay;
						ev          = kcac_pkg::EV_ARM_START;
					end
				end else if (match) begin
					if (mode_q == kcac_pkg::MODE_DISARMED) begin
						ev = kcac_pkg::EV_NOT_ACTIVE;
					end else begin
						mode_d      = kcac_pkg::MODE_DISARMED;
						tally_d     = 4'd0;
						countdown_d = 6'd0;
						ev          = kcac_pkg::EV_DISARMED;
					end
				end else begin
					ev = kcac_pkg::EV_WRONG_CODE;
					if (mode_q == kcac_pkg::MODE_ARMED) begin
						tally_d = tally_inc;
						if (tally_inc >= cfg.wrong_limit) begin
							mode_d  = kcac_pkg::MODE_ALARM;
							tally_d = 4'd0;
							ev      = kcac_pkg::EV_ALARM;
						end
					end
				end
			end else if (key.hit) begin
				wr_en   = 1'b1;
				count_d = full ? kcac_pkg::CNT_W'(1) : count_q + kcac_pkg::CNT_W'(1);
			end
		end
	end

	// Lock mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= kcac_pkg::MODE_DISARMED;
		end else begin
			mode_q <= mode_d;
		end
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= 4'd0;
			countdown_q <= 6'd0;
			count_q     <= '0;
		end else begin
			tally_q     <= tally_d;
			countdown_q <= countdown_d;
			count_q     <= count_d;
		end
	end

	// Entry buffer; slots past the fill count are never read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_idx] <= key.sym;
		end
	end

	// Status after the item
	assign count_wide       = 6'(count_d);
	assign res.mode         = mode_d;
	assign res.wrong_count  = tally_d;
	assign res.ev           = ev;
	assign res.entry_length = count_wide[4:0];

	// Checks
	`KCAC_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= kcac_pkg::CNT_W'(kcac_pkg::ENTRY_CAPACITY))
	`KCAC_ASSERT_NOW(a_countdown_idle, mode_q != kcac_pkg::MODE_ACTIVATING, countdown_q == 6'd0)
	`KCAC_ASSERT_NEXT(a_alarm_entry, step && (ev == kcac_pkg::EV_ALARM), (mode_q == kcac_pkg::MODE_ALARM) && (tally_q == 4'd0))
	`KCAC_ASSERT_NEXT(a_hold_no_step, !step, $stable(mode_q) && $stable(count_q) && $stable(tally_q))

endmodule

`default_nettype wire

/* rtl/keypad_code_alarm_controller.sv */
// ----------------------------------------------------------------------------
// Keypad code alarm controller
// Keypad scanning and code lock with arming delay and wrong-code alarm.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  input   | in_valid / in_stall       | opcode, row_levels
//  result  | out_valid / out_stall     | key_seen, key_symbol, column_driven,
//          |                           | lock_state, wrong_count, event_code,
//          |                           | entry_length
//  config  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One item per cycle sustained while the result side does not stall; a result
//  passes the input register, then the result register, before it is presented.
//  The whole update of the lock, code compare
//  included, sits between the input register and the result register.
//  Reset clears all control state at once; no clearing pass.
//  A stalled result holds while one more item may wait in the input register.
//  Configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_alarm_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [3:0]  row_levels,
	// result items
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             key_seen,
	output logic [3:0]       key_symbol,
	output logic [1:0]       column_driven,
	output logic [1:0]       lock_state,
	output logic [3:0]       wrong_count,
	output logic [2:0]       event_code,
	output logic [4:0]       entry_length,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic                  valid_s1;
	logic                  opcode_s1;
	logic [3:0]            rows_s1;
	logic                  advance;
	logic [1:0]            column_q;
	logic [1:0]            col;
	logic                  tick;
	kcac_pkg::key_t        key;
	kcac_pkg::cfg_t        cfg_q;
	kcac_pkg::lock_res_t   res;

	logic                  out_valid_q;
	logic                  key_seen_q;
	logic [3:0]            key_symbol_q;
	logic [1:0]            column_q_out;
	logic [1:0]            lock_state_q;
	logic [3:0]            wrong_count_q;
	logic [2:0]            event_code_q;
	logic [4:0]            entry_length_q;

	// Handshake: the item in the input register moves on when the result slot frees
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			rows_s1   <= row_levels;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_symbols <= kcac_pkg::RST_CODE_SYMBOLS;
			cfg_q.code_length  <= kcac_pkg::RST_CODE_LENGTH;
			cfg_q.wrong_limit  <= kcac_pkg::RST_WRONG_LIMIT;
			cfg_q.arm_delay    <= kcac_pkg::RST_ARM_DELAY;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kcac_pkg::CFG_CODE_SYMBOLS: cfg_q.code_symbols <= cfg_data;
				kcac_pkg::CFG_CODE_LENGTH:  cfg_q.code_length  <= cfg_data[4:0];
				kcac_pkg::CFG_WRONG_LIMIT:  cfg_q.wrong_limit  <= cfg_data[3:0];
				kcac_pkg::CFG_ARM_DELAY:    cfg_q.arm_delay    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Keypad scan: decode the current column, then step to the next
	assign tick = (opcode_s1 == kcac_pkg::OP_TICK);
	assign col  = (column_q > 2'd2) ? 2'd0 : column_q;

	always_comb begin
		key = kcac_pkg::decode_key(col, rows_s1);
		if (tick) key = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 2'd0;
		end else if (advance && !tick) begin
			column_q <= (col == 2'd2) ? 2'd0 : col + 2'd1;
		end
	end

	// Lock core
	kcac_lock u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick),
		.key    (key),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_seen_q     <= key.hit && !key.enter;
			key_symbol_q   <= key.sym;
			column_q_out   <= tick ? 2'd0 : col;
			lock_state_q   <= res.mode;
			wrong_count_q  <= res.wrong_count;
			event_code_q   <= res.ev;
			entry_length_q <= res.entry_length;
		end
	end

	assign out_valid     = out_valid_q;
	assign key_seen      = key_seen_q;
	assign key_symbol    = key_symbol_q;
	assign column_driven = column_q_out;
	assign lock_state    = lock_state_q;
	assign wrong_count   = wrong_count_q;
	assign event_code    = event_code_q;
	assign entry_length  = entry_length_q;

endmodule

`default_nettype wire

/* bench/kcac_lock_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm controller: result checker
// Watches the input, result and configuration channels and keeps its own
// model of the keypad scanner and code lock. It predicts one result for each
// input transfer and compares every result transfer, field by field, with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------

module kcac_lock_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        opcode,
	input  wire logic [3:0]  row_levels,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        key_seen,
	input  wire logic [3:0]  key_symbol,
	input  wire logic [1:0]  column_driven,
	input  wire logic [1:0]  lock_state,
	input  wire logic [3:0]  wrong_count,
	input  wire logic [2:0]  event_code,
	input  wire logic [4:0]  entry_length,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               results_checked,
	output int               arms_seen,
	output int               alarms_seen,
	output int               disarms_seen,
	output int               wraps_seen
);

	// One predicted result
	typedef struct packed {
		logic                 key_seen;
		logic [3:0]           key_symbol;
		logic [1:0]           column;
		kcac_pkg::lock_mode_t mode;
		logic [3:0]           wrong;
		kcac_pkg::event_t     ev;
		logic [4:0]           entry_len;
	} lock_result_t;

	// Keypad layout, nibble (col * 4 + row), row 0 first
	localparam logic [3:0]  KEY_ENTER  = 4'd11;
	localparam logic [47:0] KEY_LAYOUT = {4'd3, 4'd6, 4'd9, KEY_ENTER,
		4'd2, 4'd5, 4'd8, 4'd0, 4'd1, 4'd4, 4'd7, kcac_pkg::SYM_STAR};

	// Configuration copy
	logic [63:0] code_cfg;
	logic [4:0]  len_cfg;
	logic [3:0]  limit_cfg;
	logic [5:0]  delay_cfg;

	// Lock model state
	kcac_pkg::lock_mode_t       lock_now;
	logic [1:0]                 col_next;
	logic [3:0]                 entry_syms [kcac_pkg::ENTRY_CAPACITY];
	logic [kcac_pkg::CNT_W-1:0] entry_cnt;
	logic [3:0]                 tally;
	logic [5:0]                 countdown;

	lock_result_t expected_results [$];
	lock_result_t oldest;
	lock_result_t fresh;

	function automatic void clear_entry();
		int i;
		for (i = 0; i < kcac_pkg::ENTRY_CAPACITY; i++) entry_syms[i] = 4'd0;
		entry_cnt = '0;
	endfunction

	function automatic logic code_matches();
		int i;
		if (len_cfg > kcac_pkg::MAX_CODE_SYMBOLS || entry_cnt != len_cfg) return 1'b0;
		for (i = 0; i < len_cfg; i++)
			if (entry_syms[i] != code_cfg[4*i +: 4]) return 1'b0;
		return 1'b1;
	endfunction

	// Enter key: lone star first, then the code compare
	function automatic kcac_pkg::event_t resolve_entry();
		kcac_pkg::event_t ev;
		if (entry_cnt == 1 && entry_syms[0] == kcac_pkg::SYM_STAR) begin
			if (lock_now != kcac_pkg::MODE_DISARMED) begin
				ev = kcac_pkg::EV_ARM_REFUSED;
			end else begin
				lock_now  = kcac_pkg::MODE_ACTIVATING;
				countdown = delay_cfg;
				ev        = kcac_pkg::EV_ARM_START;
			end
		end else if (code_matches()) begin
			if (lock_now == kcac_pkg::MODE_DISARMED) begin
				ev = kcac_pkg::EV_NOT_ACTIVE;
			end else begin
				lock_now  = kcac_pkg::MODE_DISARMED;
				tally     = 4'd0;
				countdown = 6'd0;
				ev        = kcac_pkg::EV_DISARMED;
			end
		end else begin
			ev = kcac_pkg::EV_WRONG_CODE;
			if (lock_now == kcac_pkg::MODE_ARMED) begin
				tally = tally + 4'd1;
				if (tally >= limit_cfg) begin
					lock_now = kcac_pkg::MODE_ALARM;
					tally    = 4'd0;
					ev       = kcac_pkg::EV_ALARM;
				end
			end
		end
		clear_entry();
		return ev;
	endfunction

	// Next result of the lock for one item
	function automatic lock_result_t predict_item(input logic op, input logic [3:0] rows);
		lock_result_t res;
		logic [1:0]   col;
		logic [3:0]   key;
		int           row;
		res    = '0;
		res.ev = kcac_pkg::EV_NONE;
		if (op == kcac_pkg::OP_SCAN) begin
			col        = (col_next > 2'd2) ? 2'd0 : col_next;
			row        = rows[0] ? 0 : rows[1] ? 1 : rows[2] ? 2 : 3;
			key        = KEY_LAYOUT[(col * 4 + row) * 4 +: 4];
			res.column = col;
			col_next   = (col == 2'd2) ? 2'd0 : col + 2'd1;
			if (rows != 4'd0) begin
				if (key == KEY_ENTER) begin
					res.ev = resolve_entry();
				end else begin
					// full buffer restarts with this key
					if (entry_cnt >= kcac_pkg::ENTRY_CAPACITY) begin
						clear_entry();
						wraps_seen++;
					end
					entry_syms[entry_cnt] = key;
					entry_cnt             = entry_cnt + 1'b1;
					res.key_seen          = 1'b1;
					res.key_symbol        = key;
				end
			end
		end else if (lock_now == kcac_pkg::MODE_ACTIVATING) begin
			if (countdown <= 6'd1) begin
				countdown = 6'd0;
				lock_now  = kcac_pkg::MODE_ARMED;
				res.ev    = kcac_pkg::EV_ARMED;
			end else begin
				countdown = countdown - 6'd1;
			end
		end
		res.mode      = lock_now;
		res.wrong     = tally;
		res.entry_len = entry_cnt;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] result %0d: %s is %0d, expected %0d",
			$time, results_checked, what, got, want);
		fail_count++;
	endtask

	// Track transfers on all three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_cfg        = kcac_pkg::RST_CODE_SYMBOLS;
			len_cfg         = kcac_pkg::RST_CODE_LENGTH;
			limit_cfg       = kcac_pkg::RST_WRONG_LIMIT;
			delay_cfg       = kcac_pkg::RST_ARM_DELAY;
			lock_now        = kcac_pkg::MODE_DISARMED;
			col_next        = 2'd0;
			tally           = 4'd0;
			countdown       = 6'd0;
			clear_entry();
			expected_results.delete();
			fail_count      = 0;
			results_checked = 0;
			arms_seen       = 0;
			alarms_seen     = 0;
			disarms_seen    = 0;
			wraps_seen      = 0;
			pending        <= 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					kcac_pkg::CFG_CODE_SYMBOLS: code_cfg  = cfg_data;
					kcac_pkg::CFG_CODE_LENGTH:  len_cfg   = cfg_data[4:0];
					kcac_pkg::CFG_WRONG_LIMIT:  limit_cfg = cfg_data[3:0];
					kcac_pkg::CFG_ARM_DELAY:    delay_cfg = cfg_data[5:0];
					default: ;
				endcase
			end

			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing waiting, out_valid", 64'(1), 64'(0));
				end else begin
					oldest = expected_results.pop_front();
					results_checked++;
					if (key_seen !== oldest.key_seen)
						report_mismatch("key_seen", 64'(key_seen), 64'(oldest.key_seen));
					if (key_symbol !== oldest.key_symbol)
						report_mismatch("key_symbol", 64'(key_symbol),
							64'(oldest.key_symbol));
					if (column_driven !== oldest.column)
						report_mismatch("column_driven", 64'(column_driven),
							64'(oldest.column));
					if (lock_state !== oldest.mode)
						report_mismatch("lock_state", 64'(lock_state), 64'(oldest.mode));
					if (wrong_count !== oldest.wrong)
						report_mismatch("wrong_count", 64'(wrong_count), 64'(oldest.wrong));
					if (event_code !== oldest.ev)
						report_mismatch("event_code", 64'(event_code), 64'(oldest.ev));
					if (entry_length !== oldest.entry_len)
						report_mismatch("entry_length", 64'(entry_length),
							64'(oldest.entry_len));
				end
			end

			// input transfer: predict its result
			if (in_valid && !in_stall) begin
				fresh = predict_item(opcode, row_levels);
				case (fresh.ev)
					kcac_pkg::EV_ARMED:    arms_seen++;
					kcac_pkg::EV_ALARM:    alarms_seen++;
					kcac_pkg::EV_DISARMED: disarms_seen++;
					default: ;
				endcase
				expected_results.push_back(fresh);
			end
			pending <= expected_results.size();
		end
	end

endmodule

/* bench/keypad_code_alarm_controller_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code alarm controller testbench
// Types codes on the keypad scan channel, sends timer ticks and rewrites the
// lock registers between phases, with random gaps on the sender and random
// stalls on the result side. A checker beside the block predicts and compares
// every result; this module gives the verdict.
// ----------------------------------------------------------------------------

module keypad_code_alarm_controller_test;

	localparam int ITEM_TARGET    = 800;
	localparam int PHASE_COUNT    = 6;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int LONG_HOLD      = 60;

	// Register indexes the block ignores
	localparam logic [3:0] CFG_SPARE_FIRST = 4'd4;
	localparam logic [3:0] CFG_SPARE_LAST  = 4'd15;

	// Block inputs, known from time zero
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        opcode     = kcac_pkg::OP_SCAN;
	logic [3:0]  row_levels = 4'd0;
	logic        out_stall  = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic [3:0]  cfg_index  = kcac_pkg::CFG_CODE_SYMBOLS;
	logic [63:0] cfg_data   = '0;

	// Block outputs
	logic       in_stall;
	logic       out_valid;
	logic       key_seen;
	logic [3:0] key_symbol;
	logic [1:0] column_driven;
	logic [1:0] lock_state;
	logic [3:0] wrong_count;
	logic [2:0] event_code;
	logic [4:0] entry_length;
	logic       cfg_ready;

	// Checker results
	int fail_count;
	int pending;
	int results_checked;
	int arms_seen;
	int alarms_seen;
	int disarms_seen;
	int wraps_seen;

	// Stimulus state
	int          col_now      = 0;
	int          items_sent   = 0;
	int          cfg_writes   = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct  = 25;
	int          rx_idle_pct  = 46;
	int          rx_hold_left = 0;
	logic        rx_hold_req  = 1'b0;
	logic        rx_hold_done = 1'b0;
	logic [63:0] code_syms    = kcac_pkg::RST_CODE_SYMBOLS;
	logic [4:0]  code_len     = kcac_pkg::RST_CODE_LENGTH;
	logic [3:0]  wrong_lim    = kcac_pkg::RST_WRONG_LIMIT;
	logic [5:0]  arm_delay    = kcac_pkg::RST_ARM_DELAY;

	always #1 clk = ~clk;

	keypad_code_alarm_controller u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.row_levels    (row_levels),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.key_seen      (key_seen),
		.key_symbol    (key_symbol),
		.column_driven (column_driven),
		.lock_state    (lock_state),
		.wrong_count   (wrong_count),
		.event_code    (event_code),
		.entry_length  (entry_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	kcac_lock_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.row_levels      (row_levels),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.key_seen        (key_seen),
		.key_symbol      (key_symbol),
		.column_driven   (column_driven),
		.lock_state      (lock_state),
		.wrong_count     (wrong_count),
		.event_code      (event_code),
		.entry_length    (entry_length),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.arms_seen       (arms_seen),
		.alarms_seen     (alarms_seen),
		.disarms_seen    (disarms_seen),
		.wraps_seen      (wraps_seen)
	);

	// Result side: random stalls, one long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_req && !rx_hold_done) begin
			rx_hold_done = 1'b1;
			rx_hold_left = LONG_HOLD;
		end
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One item transfer; returns at the accepting rising edge
	task automatic send_item(input logic op, input logic [3:0] rows);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		row_levels <= rows;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (op == kcac_pkg::OP_SCAN) col_now = (col_now == 2) ? 0 : col_now + 1;
	endtask

	// Scan empty rows until the column comes round, then press the key;
	// higher rows may be held too, the pressed (lowest) row wins
	task automatic press_at(input int col, input int row);
		logic [3:0] mask;
		logic [3:0] rows;
		while (col_now != col) send_item(kcac_pkg::OP_SCAN, 4'b0000);
		mask = 4'hF << (row + 1);
		rows = (4'b0001 << row) | (4'($urandom) & mask);
		send_item(kcac_pkg::OP_SCAN, rows);
	endtask

	task automatic press_symbol(input logic [3:0] sym);
		case (sym)
			kcac_pkg::SYM_STAR: press_at(0, 0);
			4'd7:     press_at(0, 1);
			4'd4:     press_at(0, 2);
			4'd1:     press_at(0, 3);
			4'd0:     press_at(1, 0);
			4'd8:     press_at(1, 1);
			4'd5:     press_at(1, 2);
			4'd2:     press_at(1, 3);
			4'd9:     press_at(2, 1);
			4'd6:     press_at(2, 2);
			default:  press_at(2, 3);   // digit 3
		endcase
	endtask

	task automatic press_enter();
		press_at(2, 0);
	endtask

	// Drop valid and wait for every predicted result
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// Register write, random bits above the register width
	task automatic cfg_write(input logic [3:0] idx, input logic [63:0] value, input int width);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= ({$urandom, $urandom} << width) | value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random code whose first symbols are typable keys
	function automatic logic [63:0] make_code(input int len);
		logic [63:0] c;
		int          i;
		c = {$urandom, $urandom};
		for (i = 0; i < len && i < kcac_pkg::MAX_CODE_SYMBOLS; i++)
			c[4*i +: 4] = 4'($urandom_range(kcac_pkg::SYM_STAR));
		return c;
	endfunction

	// One random keypad sequence, mostly well formed
	task automatic run_sequence();
		int         pick;
		int         n;
		int         k;
		logic [3:0] sym;
		pick = $urandom_range(99);
		if (pick < 30) begin
			// the expected code then enter
			for (k = 0; k < code_len && k < kcac_pkg::MAX_CODE_SYMBOLS; k++) begin
				sym = code_syms[4*k +: 4];
				press_symbol((sym > kcac_pkg::SYM_STAR) ?
					4'($urandom_range(kcac_pkg::SYM_STAR)) : sym);
			end
			press_enter();
		end else if (pick < 45) begin
			// lone star, then ticks through the arming delay most times
			press_symbol(kcac_pkg::SYM_STAR);
			press_enter();
			n = ($urandom_range(9) < 7) ? arm_delay + $urandom_range(2) : $urandom_range(arm_delay);
			repeat (n) send_item(kcac_pkg::OP_TICK, 4'($urandom));
		end else if (pick < 65) begin
			// short random entry
			n = $urandom_range(8, 1);
			repeat (n) press_symbol(4'($urandom_range(kcac_pkg::SYM_STAR)));
			press_enter();
		end else if (pick < 75) begin
			n = $urandom_range(6, 1);
			repeat (n) send_item(kcac_pkg::OP_TICK, 4'($urandom));
		end else if (pick < 87) begin
			// raw noise
			n = $urandom_range(6, 1);
			repeat (n) send_item(1'($urandom_range(1)), 4'($urandom_range(15)));
		end else if (pick < 94) begin
			// long entry, from just under to past the buffer capacity
			n = $urandom_range(kcac_pkg::ENTRY_CAPACITY + 4, kcac_pkg::ENTRY_CAPACITY - 1);
			repeat (n) press_symbol(4'($urandom_range(kcac_pkg::SYM_STAR)));
			press_enter();
		end else begin
			press_enter();
		end
	endtask

	initial begin
		int k;
		int phase;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every row pattern, tick while disarmed, arm and refusal
		for (k = 0; k < 16; k++) send_item(kcac_pkg::OP_SCAN, 4'(k));
		send_item(kcac_pkg::OP_TICK, 4'hF);
		press_enter();
		press_symbol(kcac_pkg::SYM_STAR);
		press_enter();
		send_item(kcac_pkg::OP_TICK, 4'h0);
		press_symbol(kcac_pkg::SYM_STAR);
		press_enter();

		// Random phases, each with its own register settings
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: begin
						code_len  = 5'd4;
						wrong_lim = 4'd1;
						arm_delay = 6'd0;
					end
					2: begin
						code_len  = 5'd16;
						wrong_lim = 4'd15;
						arm_delay = 6'd63;
					end
					3: begin
						code_len  = 5'd0;
						wrong_lim = 4'd0;
						arm_delay = 6'd1;
					end
					4: begin
						code_len  = 5'($urandom_range(31, kcac_pkg::MAX_CODE_SYMBOLS + 1));
						wrong_lim = 4'($urandom_range(15, 1));
						arm_delay = 6'($urandom_range(8));
					end
					default: begin
						code_len  = 5'($urandom_range(8, 1));
						wrong_lim = 4'($urandom_range(5, 2));
						arm_delay = 6'($urandom_range(5));
					end
				endcase
				code_syms = make_code((phase == 4) ? 0 : int'(code_len));
				cfg_write(kcac_pkg::CFG_CODE_SYMBOLS, code_syms, 64);
				cfg_write(kcac_pkg::CFG_CODE_LENGTH, 64'(code_len), 5);
				cfg_write(kcac_pkg::CFG_WRONG_LIMIT, 64'(wrong_lim), 4);
				cfg_write(kcac_pkg::CFG_ARM_DELAY, 64'(arm_delay), 6);
				if (phase == 1) begin
					cfg_write(CFG_SPARE_LAST, {$urandom, $urandom}, 64);
					cfg_write(4'($urandom_range(CFG_SPARE_LAST - 1, CFG_SPARE_FIRST)),
						{$urandom, $urandom}, 64);
				end
			end
			tx_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 46 : 0;
			rx_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 25 : 0;
			if (phase == 1) rx_hold_req = 1'b1;
			while (items_sent < (phase + 1) * ITEM_TARGET / PHASE_COUNT) run_sequence();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d register writes over %0d settings of the lock.",
			items_sent, cfg_writes, PHASE_COUNT);
		$display("Checked %0d results: %0d armed, %0d alarms, %0d disarms, %0d buffer restarts.",
			results_checked, arms_seen, alarms_seen, disarms_seen, wraps_seen);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/kcac_pkg.sv
rtl/kcac_lock.sv
rtl/keypad_code_alarm_controller.sv
bench/kcac_lock_checker.sv
bench/keypad_code_alarm_controller_test.sv
